@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the small label area filter.
// Depends on nothing; take it in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset (active-low reset).
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ hdl/slaf_pkg.sv @@
// Package of the small label area filter: widths, command codes, FSM states
// and the histogram request bundle. Depends on nothing.
`default_nettype none

package slaf_pkg;

    localparam int unsigned LABEL_W     = 8;
    localparam int unsigned FACE_AREA_W = 24;
    localparam int unsigned AREA_W      = 36;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned SPLIT_W     = 18;   // low half of the grand total
    localparam int unsigned CMP_W       = AREA_W + FRAC_W;

    localparam logic [FRAC_W-1:0] MIN_FRACTION_RESET = 16'd328;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_RD_LBL,
        ST_RD_HIST
    } t_state;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic               clear;
        logic [LABEL_W-1:0] addr;
        logic [AREA_W-1:0]  wr_data;
    } t_hist_req;

endpackage

`default_nettype wire

@@ hdl/small_label_area_filter.sv @@
// Small label area filter: top level with command sequencer and counters.
// Depends on slaf_pkg, slaf_label_store, slaf_hist_store, slaf_thresh.
`default_nettype none

`include "assert_macros.svh"

// Faces are loaded one per transfer with a cluster label and an area; the
// label is kept in load order and the area is added, saturating at 2^36-1,
// to a per-label histogram and to a grand total. A read command returns the
// next stored face, its label and a removed flag that is set when the
// cluster's area times 65536 is below min_fraction times the grand total,
// with last marking the final stored face. Clear empties histogram and
// counters at once (histogram entries carry valid bits, so there is no
// clearing pass after reset or clear). Loads past MAX_FACES, loads with a
// label at or above NUM_LABELS, reads with nothing left and command 3 are
// taken and dropped without a result. One item is in work at a time: a
// load reads the histogram entry, then writes it back (read-modify-write
// through its one memory port), a read-out runs label store read, histogram
// read and compare, then waits while the result register still holds the
// previous result; clear and dropped items leave the block idle.
// min_fraction is written through its own valid/ready port, always ready;
// write it only while the block is idle.
module small_label_area_filter #(
    parameter int unsigned MAX_FACES  = 4096,
    parameter int unsigned NUM_LABELS = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [slaf_pkg::FRAC_W-1:0]      i_cfg_min_fraction,
    // input items
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_command,
    input  wire logic [slaf_pkg::LABEL_W-1:0]     i_face_label,
    input  wire logic [slaf_pkg::FACE_AREA_W-1:0] i_face_area,
    // result items
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [slaf_pkg::LABEL_W-1:0]     o_out_label,
    output logic                                  o_removed,
    output logic                                  o_last
);

    localparam int unsigned CNT_W  = $clog2(MAX_FACES + 1);
    localparam int unsigned ADDR_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int unsigned LBL_CMP_W = 17;     // holds NUM_LABELS up to 65536

    slaf_pkg::t_state                  r_state, n_state;
    logic [CNT_W-1:0]                  r_face_count, n_face_count;
    logic [CNT_W-1:0]                  r_rd_ptr, n_rd_ptr;
    logic [slaf_pkg::AREA_W-1:0]       r_total, n_total;
    logic [slaf_pkg::FRAC_W-1:0]       r_min_fraction;
    logic [slaf_pkg::FACE_AREA_W-1:0]  r_area;
    logic [slaf_pkg::LABEL_W-1:0]      r_label, n_label;
    logic                              r_last_pend, n_last_pend;
    logic                              r_out_valid, n_out_valid;
    logic [slaf_pkg::LABEL_W-1:0]      r_out_label;
    logic                              r_removed;
    logic                              r_last;

    logic                              in_xfer;
    logic                              out_free;
    logic                              load_ok;
    logic                              read_ok;
    logic                              lbl_in_ok;
    logic                              lbl_rd_ok;
    logic                              out_load;
    logic                              thresh_en;
    logic                              store_wr_en;
    logic                              store_rd_en;
    slaf_pkg::t_hist_req               hist_req;
    logic [slaf_pkg::AREA_W-1:0]       hist_rd_data;
    logic [slaf_pkg::AREA_W-1:0]       hist_value;
    logic [slaf_pkg::LABEL_W-1:0]      store_rd_data;
    logic                              below;
    logic [slaf_pkg::AREA_W:0]         hist_sum;
    logic [slaf_pkg::AREA_W:0]         total_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != slaf_pkg::ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign lbl_in_ok = (LBL_CMP_W'(i_face_label) < LBL_CMP_W'(NUM_LABELS));
    assign lbl_rd_ok = (LBL_CMP_W'(r_label) < LBL_CMP_W'(NUM_LABELS));
    assign load_ok   = (i_command == slaf_pkg::CMD_LOAD) && lbl_in_ok
                       && (r_face_count < CNT_W'(MAX_FACES));
    assign read_ok   = (i_command == slaf_pkg::CMD_READ) && (r_rd_ptr < r_face_count);

    // Saturating sums for the histogram entry and the grand total.
    assign hist_sum  = {1'b0, hist_rd_data} + (slaf_pkg::AREA_W + 1)'(r_area);
    assign total_sum = {1'b0, r_total} + (slaf_pkg::AREA_W + 1)'(i_face_area);

    assign hist_value = lbl_rd_ok ? hist_rd_data : '0;

    always_comb begin
        n_state      = r_state;
        n_face_count = r_face_count;
        n_rd_ptr     = r_rd_ptr;
        n_total      = r_total;
        n_label      = r_label;
        n_last_pend  = r_last_pend;
        store_wr_en  = 1'b0;
        store_rd_en  = 1'b0;
        thresh_en    = 1'b0;
        out_load     = 1'b0;
        hist_req     = '0;

        unique case (r_state)
            slaf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    priority if (load_ok) begin
                        // write label now, read histogram entry for the add
                        store_wr_en   = 1'b1;
                        hist_req.rd_en = 1'b1;
                        hist_req.addr  = i_face_label;
                        n_label       = i_face_label;
                        n_face_count  = CNT_W'(r_face_count + 1'b1);
                        n_total       = total_sum[slaf_pkg::AREA_W]
                                        ? '1 : total_sum[slaf_pkg::AREA_W-1:0];
                        n_state       = slaf_pkg::ST_LOAD_WR;
                    end else if (read_ok) begin
                        store_rd_en = 1'b1;
                        n_last_pend = (CNT_W'(r_rd_ptr + 1'b1) == r_face_count);
                        n_rd_ptr    = CNT_W'(r_rd_ptr + 1'b1);
                        n_state     = slaf_pkg::ST_RD_LBL;
                    end else if (i_command == slaf_pkg::CMD_CLEAR) begin
                        hist_req.clear = 1'b1;
                        n_face_count   = '0;
                        n_rd_ptr       = '0;
                        n_total        = '0;
                    end else begin
                        // drop: full, bad label, nothing to read, unused code
                    end
                end
            end
            slaf_pkg::ST_LOAD_WR: begin
                hist_req.wr_en   = 1'b1;
                hist_req.addr    = r_label;
                hist_req.wr_data = hist_sum[slaf_pkg::AREA_W]
                                   ? '1 : hist_sum[slaf_pkg::AREA_W-1:0];
                n_state          = slaf_pkg::ST_IDLE;
            end
            slaf_pkg::ST_RD_LBL: begin
                // label arrives; fetch its histogram entry, form the threshold
                hist_req.rd_en = 1'b1;
                hist_req.addr  = store_rd_data;
                n_label        = store_rd_data;
                thresh_en      = 1'b1;
                n_state        = slaf_pkg::ST_RD_HIST;
            end
            slaf_pkg::ST_RD_HIST: begin
                // hold until the result register is free
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = slaf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slaf_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= slaf_pkg::ST_IDLE;
            r_face_count   <= '0;
            r_rd_ptr       <= '0;
            r_total        <= '0;
            r_min_fraction <= slaf_pkg::MIN_FRACTION_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_face_count <= n_face_count;
            r_rd_ptr     <= n_rd_ptr;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_fraction <= i_cfg_min_fraction;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_label     <= n_label;
        r_last_pend <= n_last_pend;
        if (in_xfer) begin
            r_area <= i_face_area;
        end
        if (out_load) begin
            r_out_label <= r_label;
            r_removed   <= below;
            r_last      <= r_last_pend;
        end
    end

    slaf_label_store #(
        .DEPTH(MAX_FACES)
    ) u_label_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr_en),
        .i_wr_addr (r_face_count[ADDR_W-1:0]),
        .i_wr_data (i_face_label),
        .i_rd_en   (store_rd_en),
        .i_rd_addr (r_rd_ptr[ADDR_W-1:0]),
        .o_rd_data (store_rd_data)
    );

    slaf_hist_store #(
        .NUM_LABELS(NUM_LABELS)
    ) u_hist_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hist_req),
        .o_rd_data (hist_rd_data)
    );

    slaf_thresh u_thresh (
        .i_clk          (i_clk),
        .i_en           (thresh_en),
        .i_min_fraction (r_min_fraction),
        .i_total        (r_total),
        .i_hist         (hist_value),
        .o_below        (below)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_label = r_out_label;
    assign o_removed   = r_removed;
    assign o_last      = r_last;

    `ASSERT_CLK_RST(a_ptr_within_count, i_clk, i_rst_n, r_rd_ptr <= r_face_count)
    `ASSERT_CLK_RST(a_count_within_cap, i_clk, i_rst_n, r_face_count <= CNT_W'(MAX_FACES))
    `ASSERT_CLK_RST(a_result_from_lookup, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state) == slaf_pkg::ST_RD_HIST)
    `ASSERT_CLK_RST(a_load_writes_back, i_clk, i_rst_n, r_state == slaf_pkg::ST_LOAD_WR |=> r_state == slaf_pkg::ST_IDLE)

endmodule

`default_nettype wire

@@ hdl/slaf_label_store.sv @@
// Label store: one synchronous memory of face labels in load order.
// Depends on slaf_pkg for the label width.
`default_nettype none

module slaf_label_store #(
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [slaf_pkg::LABEL_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [slaf_pkg::LABEL_W-1:0] o_rd_data
);

    logic [slaf_pkg::LABEL_W-1:0] r_mem [DEPTH];
    logic [slaf_pkg::LABEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/slaf_hist_store.sv @@
// Per-label area histogram: synchronous memory plus one valid bit per entry,
// so a clear takes effect at once. Depends on slaf_pkg for the request type.
`default_nettype none

module slaf_hist_store #(
    parameter int unsigned NUM_LABELS = 256,
    localparam int unsigned DEPTH  = (NUM_LABELS < 256) ? NUM_LABELS : 256,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire slaf_pkg::t_hist_req        i_req,
    output logic      [slaf_pkg::AREA_W-1:0] o_rd_data
);

    logic [slaf_pkg::AREA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]            r_valid;
    logic [slaf_pkg::AREA_W-1:0] r_rd_data;
    logic                        r_rd_valid;
    logic [ADDR_W-1:0]           addr;

    assign addr = i_req.addr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // Valid bits: drop all on reset or clear, mark an entry on write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

@@ hdl/slaf_thresh.sv @@
// Removal threshold: min_fraction times grand total as two registered
// 16x18 partial products, then one wide add and compare. Depends on slaf_pkg.
`default_nettype none

module slaf_thresh (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [slaf_pkg::FRAC_W-1:0] i_min_fraction,
    input  wire logic [slaf_pkg::AREA_W-1:0] i_total,
    input  wire logic [slaf_pkg::AREA_W-1:0] i_hist,
    output logic                             o_below
);

    localparam int unsigned PP_W = slaf_pkg::FRAC_W + slaf_pkg::SPLIT_W;
    localparam int unsigned HI_W = slaf_pkg::AREA_W - slaf_pkg::SPLIT_W;

    logic [PP_W-1:0]              r_pp_hi;
    logic [PP_W-1:0]              r_pp_lo;
    logic [slaf_pkg::CMP_W-1:0]   rhs;
    logic [slaf_pkg::CMP_W-1:0]   lhs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_hi <= PP_W'(i_min_fraction * i_total[slaf_pkg::AREA_W-1 -: HI_W]);
            r_pp_lo <= PP_W'(i_min_fraction * i_total[slaf_pkg::SPLIT_W-1:0]);
        end
    end

    assign rhs = {r_pp_hi, {slaf_pkg::SPLIT_W{1'b0}}} + slaf_pkg::CMP_W'(r_pp_lo);
    assign lhs = {i_hist, {slaf_pkg::FRAC_W{1'b0}}};

    assign o_below = (lhs < rhs);

endmodule

`default_nettype wire
